// File: src/i2cbr_pkg.sv
// i2cbr_pkg: types and constants shared by the i2c bus recovery sequencer
// no dependencies
package i2cbr_pkg;

    localparam int HalfWidth  = 16;
    localparam int ClockWidth = 4;

    localparam logic [HalfWidth-1:0]  HalfReset  = 16'd5;
    localparam logic [ClockWidth-1:0] ClockReset = 4'd9;

    typedef enum logic [0:0] {
        REG_HALF_PERIOD = 1'b0,
        REG_MAX_CLOCKS  = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        ACT_TICK  = 1'b0,
        ACT_START = 1'b1
    } action_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_SDA_REL  = 4'd1,
        PH_SCL_REL  = 4'd2,
        PH_CLK_LOW  = 4'd3,
        PH_CLK_SDA  = 4'd4,
        PH_CLK_HIGH = 4'd5,
        PH_STP_SCLL = 4'd6,
        PH_STP_SDAL = 4'd7,
        PH_STP_SCLH = 4'd8,
        PH_STP_SDAH = 4'd9,
        PH_SETTLE1  = 4'd10,
        PH_SETTLE2  = 4'd11
    } phase_t;

    typedef struct packed {
        logic action;
        logic sda_level;
    } tick_item_t;

    typedef struct packed {
        logic                  scl_drive_low;
        logic                  sda_drive_low;
        logic                  busy_res;
        logic                  done_res;
        logic                  sda_released;
        logic [ClockWidth-1:0] clocks_used;
    } result_item_t;

endpackage

// File: src/i2cbr_if.sv
// i2cbr_if: valid/ready channels for tick items and result items
// depends on i2cbr_pkg
interface i2cbr_tick_if;
    import i2cbr_pkg::*;

    logic       valid;
    logic       ready;
    tick_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cbr_result_if;
    import i2cbr_pkg::*;

    logic         valid;
    logic         ready;
    result_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/i2c_bus_recovery_sequencer.sv
// i2c_bus_recovery_sequencer: top level with config registers and result register
// depends on i2cbr_pkg, i2cbr_if and i2cbr_seq
//
//  channel  dir  payload                                   handshake
//  tick     in   action, sda_level                         valid/ready
//  result   out  scl/sda drives, busy, done, freed, count  valid/ready
//  cfg      in   cfg_index, cfg_data                       cfg_we, no wait
//
// one tick item per cycle unless stalled; results follow the cycle after transfer
// the state machine and counters update in the same cycle as the transfer
// tick ready is high while the result register is empty or being drained
// reset clears state, config returns to HalfReset ticks and ClockReset clocks
module i2c_bus_recovery_sequencer (
    input  logic                             clk,
    input  logic                             rst_n,
    i2cbr_tick_if.sink                       tick,
    i2cbr_result_if.source                   result,
    input  logic                             cfg_we,
    input  logic [0:0]                       cfg_index,
    input  logic [i2cbr_pkg::HalfWidth-1:0]   cfg_data
);
    import i2cbr_pkg::*;

    logic [HalfWidth-1:0]  half_reg;
    logic [ClockWidth-1:0] max_reg;
    logic                  out_valid_reg;
    result_item_t          out_data_reg;
    result_item_t          result_next;
    logic                  accept;

    assign tick.ready = !out_valid_reg || result.ready;
    assign accept     = tick.valid && tick.ready;

    i2cbr_seq u_seq (
        .clk               (clk),
        .rst_n             (rst_n),
        .step_en           (accept),
        .item              (tick.data),
        .half_period_ticks (half_reg),
        .max_clocks        (max_reg),
        .result_next       (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= HalfReset;
            max_reg  <= ClockReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_HALF_PERIOD: half_reg <= cfg_data;
                REG_MAX_CLOCKS:  max_reg  <= cfg_data[ClockWidth-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= result_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

// File: src/i2cbr_seq.sv
// i2cbr_seq: recovery state machine, half-period counter and pulse counter
// depends on i2cbr_pkg; gives the result that follows each stepped item
module i2cbr_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step_en,
    input  i2cbr_pkg::tick_item_t           item,
    input  logic [i2cbr_pkg::HalfWidth-1:0]  half_period_ticks,
    input  logic [i2cbr_pkg::ClockWidth-1:0] max_clocks,
    output i2cbr_pkg::result_item_t         result_next
);
    import i2cbr_pkg::*;

    phase_t                phase_reg,  phase_next;
    logic [HalfWidth-1:0]  wait_reg,   wait_next;
    logic [ClockWidth-1:0] count_reg,  count_next;
    logic                  freed_reg,  freed_next;
    logic                  scl_reg,    scl_next;
    logic                  sda_reg,    sda_next;
    logic                  done;

    logic                  busy;
    logic                  start;
    logic                  tick;
    logic                  advance;
    logic [HalfWidth-1:0]  load_value;
    logic [ClockWidth-1:0] limit;
    logic [ClockWidth-1:0] count_inc;

    assign busy       = (phase_reg != PH_IDLE);
    assign start      = step_en && (item.action == ACT_START) && !busy;
    assign tick       = step_en && (item.action == ACT_TICK) && busy;
    assign advance    = tick && (wait_reg <= HalfWidth'(1));
    assign load_value = (half_period_ticks == '0) ? HalfWidth'(1) : half_period_ticks;
    assign limit      = (max_clocks == '0) ? ClockWidth'(1) : max_clocks;
    assign count_inc  = count_reg + ClockWidth'(1);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (start)
        begin
            phase_next = PH_SDA_REL;
        end
        else if (advance)
        begin
            case (phase_reg)
                PH_SDA_REL:  phase_next = PH_SCL_REL;
                PH_SCL_REL:  phase_next = PH_CLK_LOW;
                PH_CLK_LOW:  phase_next = PH_CLK_SDA;
                PH_CLK_SDA:  phase_next = PH_CLK_HIGH;
                PH_CLK_HIGH:
                begin
                    if (item.sda_level || (count_inc >= limit))
                        phase_next = PH_STP_SCLL;
                    else
                        phase_next = PH_CLK_LOW;
                end
                PH_STP_SCLL: phase_next = PH_STP_SDAL;
                PH_STP_SDAL: phase_next = PH_STP_SCLH;
                PH_STP_SCLH: phase_next = PH_STP_SDAH;
                PH_STP_SDAH: phase_next = PH_SETTLE1;
                PH_SETTLE1:  phase_next = PH_SETTLE2;
                default:     phase_next = PH_IDLE;
            endcase
        end
    end

    // outputs and datapath
    always_comb
    begin
        wait_next  = wait_reg;
        count_next = count_reg;
        freed_next = freed_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        done       = 1'b0;
        if (start)
        begin
            wait_next  = load_value;
            count_next = '0;
            freed_next = 1'b0;
            sda_next   = 1'b0;
        end
        else if (advance)
        begin
            wait_next = load_value;
            case (phase_reg)
                PH_SDA_REL:  scl_next = 1'b0;
                PH_SCL_REL:
                begin
                    if (item.sda_level)
                        freed_next = 1'b1;
                    scl_next = 1'b1;
                end
                PH_CLK_LOW:  sda_next = 1'b0;
                PH_CLK_SDA:  scl_next = 1'b0;
                PH_CLK_HIGH:
                begin
                    count_next = count_inc;
                    scl_next   = 1'b1;
                    if (item.sda_level)
                        freed_next = 1'b1;
                end
                PH_STP_SCLL: sda_next = 1'b1;
                PH_STP_SDAL: scl_next = 1'b0;
                PH_STP_SCLH: sda_next = 1'b0;
                PH_STP_SDAH,
                PH_SETTLE1:  ;
                default:
                begin
                    wait_next = '0;
                    scl_next  = 1'b0;
                    sda_next  = 1'b0;
                    done      = 1'b1;
                end
            endcase
        end
        else if (tick)
        begin
            wait_next = wait_reg - HalfWidth'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            wait_reg  <= '0;
            count_reg <= '0;
            freed_reg <= 1'b0;
            scl_reg   <= 1'b0;
            sda_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            wait_reg  <= wait_next;
            count_reg <= count_next;
            freed_reg <= freed_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
        end
    end

    assign result_next.scl_drive_low = scl_next;
    assign result_next.sda_drive_low = sda_next;
    assign result_next.busy_res      = (phase_next != PH_IDLE);
    assign result_next.done_res      = done;
    assign result_next.sda_released  = freed_next;
    assign result_next.clocks_used   = count_next;

endmodule
